[rtl/core/lts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, codes and helpers of the lottery ticket scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int TK_W   = 7;
    localparam int PR_W   = 4;
    localparam int RND_W  = 31;
    localparam int CNT_W  = 5;
    localparam int OTOT_W = 13;

    localparam logic [2:0] KIND_START_SYS = 3'd0;
    localparam logic [2:0] KIND_START_INH = 3'd1;
    localparam logic [2:0] KIND_STOP      = 3'd2;
    localparam logic [2:0] KIND_CHANGE    = 3'd3;
    localparam logic [2:0] KIND_EXPIRE    = 3'd4;

    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_UNUSED     = 3'd1;
    localparam logic [2:0] STAT_BUSY       = 3'd2;
    localparam logic [2:0] STAT_NO_PARENT  = 3'd3;
    localparam logic [2:0] STAT_NO_TICKETS = 3'd4;

    localparam logic [PR_W-1:0] Q_WINNER      = 4'd12;
    localparam logic [PR_W-1:0] Q_PREV_WINNER = 4'd13;
    localparam logic [PR_W-1:0] Q_LOWEST      = 4'd14;

    localparam logic [2:0] CFG_MAX   = 3'd0;
    localparam logic [2:0] CFG_MIN   = 3'd1;
    localparam logic [2:0] CFG_START = 3'd2;
    localparam logic [2:0] CFG_PEN   = 3'd3;
    localparam logic [2:0] CFG_BONUS = 3'd4;

    localparam logic [TK_W-1:0] RST_MAX   = 7'd100;
    localparam logic [TK_W-1:0] RST_MIN   = 7'd1;
    localparam logic [TK_W-1:0] RST_START = 7'd20;
    localparam logic [TK_W-1:0] RST_PEN   = 7'd2;
    localparam logic [TK_W-1:0] RST_BONUS = 7'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_WIN_PR,
        ST_WIN_RD,
        ST_WIN_EXEC,
        ST_DRAW,
        ST_MOD,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FIN_RD,
        ST_OUT
    } lts_state_t;

    typedef struct packed {
        logic we_use;
        logic use_val;
        logic we_tk;
        logic we_pr;
    } lts_wr_ctl_t;

    function automatic logic [TK_W-1:0] lts_clamp(input logic signed [8:0] v,
                                                  input logic [TK_W-1:0] lo,
                                                  input logic [TK_W-1:0] hi);
        logic signed [8:0] slo;
        logic signed [8:0] shi;
        logic [TK_W-1:0]   r;
        slo = $signed({2'b00, lo});
        shi = $signed({2'b00, hi});
        if (v < slo)
        begin
            r = lo;
        end
        else if (v > shi)
        begin
            r = hi;
        end
        else
        begin
            r = v[TK_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/lottery_ticket_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_top
// Lottery scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats arrive on in_valid/in_ready; each yields one result beat on
//   out_valid/out_ready. Registers are written on cfg_valid/cfg_ready (always
//   ready); the user must write them only while the block is idle, since the
//   block itself does not enforce this; indexes past the list are ignored.
//   in_ready is high only in the idle state: one request at a time. For start,
//   stop, change and expiry without draw, a request passes through ST_RD,
//   ST_EXEC, ST_FIN_RD and ST_OUT before its result beat is registered.
//   A draw adds ST_DRAW, ST_MOD (one bit per cycle in the remainder unit)
//   and ST_WALK_RD and ST_WALK_CHK for each slot walked, since the ticket
//   memory has one read port with registered data.
//   Reset clears all in-use flags, the ticket total and the winner, and
//   loads the register defaults; no clearing pass is needed.
//   A stalled result holds in the output register; the next request is
//   taken once the result beat has left or while it waits, but its own
//   result waits for the register to empty.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_top
    import lts_pkg::*;
#(
    parameter int NUM_SLOTS = 64
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [TK_W-1:0]     cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          kind,
    input  logic [5:0]          slot,
    input  logic [5:0]          parent_slot,
    input  logic [PR_W-1:0]     start_priority,
    input  logic signed [7:0]   ticket_change,
    input  logic [RND_W-1:0]    random_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic                ran_lottery,
    output logic                winner_valid,
    output logic [5:0]          winner_slot,
    output logic [TK_W-1:0]     slot_tickets,
    output logic [PR_W-1:0]     slot_priority,
    output logic [OTOT_W-1:0]   ticket_total
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUM_W = $clog2(NUM_SLOTS * 127 + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    lts_state_t state_reg, state_next;

    logic [TK_W-1:0] max_reg, min_reg, start_reg, pen_reg, bonus_reg;

    logic [2:0]         kind_reg;
    logic [IDX_W-1:0]   s_reg;
    logic               inside_reg;
    logic               par_ok_reg;
    logic [PR_W-1:0]    sprio_reg;
    logic signed [7:0]  chg_reg;
    logic [RND_W-1:0]   rnd_reg;

    logic [2:0]         stat_reg, stat_next;
    logic               ran_reg, ran_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]   win_reg, win_next;
    logic               pres_reg, pres_next;
    logic [IDX_W-1:0]   walk_reg, walk_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;

    logic               ov_reg;
    logic [2:0]         o_stat_reg;
    logic               o_ran_reg, o_wv_reg;
    logic [5:0]         o_ws_reg;
    logic [TK_W-1:0]    o_tk_reg;
    logic [PR_W-1:0]    o_pr_reg;
    logic [OTOT_W-1:0]  o_tot_reg;

    lts_wr_ctl_t          wr_ctl;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [TK_W-1:0]      wr_tk;
    logic [PR_W-1:0]      wr_pr;
    logic                 rd_use;
    logic [TK_W-1:0]      rd_tk;
    logic [PR_W-1:0]      rd_pr;
    logic [NUM_SLOTS-1:0] use_vec;

    logic               mod_start, mod_busy, mod_done;
    logic [SUM_W-1:0]   mod_rem;

    logic [TK_W-1:0]    cur_tk;
    logic               used;
    logic [TK_W-1:0]    nv_tk;
    logic               out_free;
    logic [SUM_W-1:0]   acc_sum;

    assign cur_tk   = rd_use ? rd_tk : '0;
    assign used     = inside_reg && rd_use;
    assign out_free = !ov_reg || out_ready;
    assign acc_sum  = acc_reg + SUM_W'(cur_tk);

    lts_table #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_ctl  (wr_ctl),
        .wr_addr (wr_addr),
        .wr_tk   (wr_tk),
        .wr_pr   (wr_pr),
        .rd_addr (rd_addr),
        .rd_use  (rd_use),
        .rd_tk   (rd_tk),
        .rd_pr   (rd_pr),
        .use_vec (use_vec)
    );

    lts_mod #(
        .SUM_W (SUM_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rnd_reg),
        .divisor  (total_reg),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_FIN_RD;
                if (kind_reg == KIND_EXPIRE && inside_reg && used)
                begin
                    if (rd_pr == Q_WINNER)
                    begin
                        state_next = ST_DRAW;
                    end
                    else if (rd_pr == Q_PREV_WINNER)
                    begin
                        state_next = pres_reg ? ST_WIN_PR : ST_DRAW;
                    end
                    else if (rd_pr == Q_LOWEST)
                    begin
                        state_next = pres_reg ? ST_WIN_RD : ST_DRAW;
                    end
                end
            end
            ST_WIN_PR:
            begin
                state_next = ST_DRAW;
            end
            ST_WIN_RD:
            begin
                state_next = ST_WIN_EXEC;
            end
            ST_WIN_EXEC:
            begin
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                state_next = (total_reg == '0) ? ST_FIN_RD : ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK:
            begin
                if ((rd_use && acc_sum > mod_rem) || walk_reg == LAST_IDX)
                begin
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_FIN_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb
    begin
        wr_ctl        = '0;
        wr_addr       = s_reg;
        wr_tk         = '0;
        wr_pr         = '0;
        rd_addr       = s_reg;
        mod_start     = 1'b0;
        nv_tk         = '0;
        stat_next     = stat_reg;
        ran_next      = ran_reg;
        total_next    = total_reg;
        win_next      = win_reg;
        pres_next     = pres_reg;
        walk_next     = walk_reg;
        acc_next      = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                stat_next = STAT_OK;
                ran_next  = 1'b0;
            end
            ST_EXEC:
            begin
                if (kind_reg <= KIND_EXPIRE && !inside_reg)
                begin
                    stat_next = STAT_UNUSED;
                end
                else if (kind_reg == KIND_START_SYS || kind_reg == KIND_START_INH)
                begin
                    if (used)
                    begin
                        stat_next = STAT_BUSY;
                    end
                    else if (kind_reg == KIND_START_SYS)
                    begin
                        wr_ctl = '{we_use: 1'b1, use_val: 1'b1, we_tk: 1'b1, we_pr: 1'b1};
                        wr_pr  = sprio_reg;
                    end
                    else if (!par_ok_reg)
                    begin
                        stat_next = STAT_NO_PARENT;
                    end
                    else
                    begin
                        wr_ctl     = '{we_use: 1'b1, use_val: 1'b1, we_tk: 1'b1, we_pr: 1'b1};
                        wr_pr      = Q_LOWEST;
                        wr_tk      = start_reg;
                        total_next = total_reg + SUM_W'(start_reg);
                    end
                end
                else if (kind_reg <= KIND_EXPIRE && !used)
                begin
                    stat_next = STAT_UNUSED;
                end
                else if (kind_reg == KIND_STOP)
                begin
                    wr_ctl     = '{we_use: 1'b1, use_val: 1'b0, we_tk: 1'b1, we_pr: 1'b0};
                    total_next = total_reg - SUM_W'(cur_tk);
                    if (pres_reg && win_reg == s_reg)
                    begin
                        pres_next = 1'b0;
                    end
                end
                else if (kind_reg == KIND_CHANGE)
                begin
                    nv_tk      = lts_clamp($signed({2'b00, cur_tk}) +
                                           $signed({chg_reg[7], chg_reg}), min_reg, max_reg);
                    wr_ctl     = '{we_use: 1'b0, use_val: 1'b0, we_tk: 1'b1, we_pr: 1'b0};
                    wr_tk      = nv_tk;
                    total_next = total_reg - SUM_W'(cur_tk) + SUM_W'(nv_tk);
                end
                else if (kind_reg == KIND_EXPIRE)
                begin
                    nv_tk      = lts_clamp($signed({2'b00, cur_tk}) -
                                           $signed({2'b00, pen_reg}), min_reg, max_reg);
                    wr_ctl     = '{we_use: 1'b0, use_val: 1'b0, we_tk: 1'b1, we_pr: 1'b1};
                    wr_tk      = nv_tk;
                    wr_pr      = Q_LOWEST;
                    total_next = total_reg - SUM_W'(cur_tk) + SUM_W'(nv_tk);
                end
            end
            ST_WIN_PR:
            begin
                wr_ctl  = '{we_use: 1'b0, use_val: 1'b0, we_tk: 1'b0, we_pr: 1'b1};
                wr_addr = win_reg;
                wr_pr   = Q_PREV_WINNER;
            end
            ST_WIN_RD:
            begin
                rd_addr = win_reg;
            end
            ST_WIN_EXEC:
            begin
                nv_tk      = lts_clamp($signed({2'b00, cur_tk}) +
                                       $signed({2'b00, bonus_reg}), min_reg, max_reg);
                wr_ctl     = '{we_use: 1'b0, use_val: 1'b0, we_tk: 1'b1, we_pr: 1'b1};
                wr_addr    = win_reg;
                wr_tk      = nv_tk;
                wr_pr      = Q_PREV_WINNER;
                total_next = total_reg - SUM_W'(cur_tk) + SUM_W'(nv_tk);
            end
            ST_DRAW:
            begin
                if (total_reg == '0)
                begin
                    stat_next = STAT_NO_TICKETS;
                end
                else
                begin
                    mod_start = 1'b1;
                    ran_next  = 1'b1;
                    walk_next = '0;
                    acc_next  = '0;
                end
            end
            ST_WALK_RD:
            begin
                rd_addr = walk_reg;
            end
            ST_WALK_CHK:
            begin
                acc_next  = acc_sum;
                walk_next = walk_reg + 1'b1;
                if (rd_use && acc_sum > mod_rem)
                begin
                    wr_ctl    = '{we_use: 1'b0, use_val: 1'b0, we_tk: 1'b0, we_pr: 1'b1};
                    wr_addr   = walk_reg;
                    wr_pr     = Q_WINNER;
                    win_next  = walk_reg;
                    pres_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_reg      <= RST_MAX;
            min_reg      <= RST_MIN;
            start_reg    <= RST_START;
            pen_reg      <= RST_PEN;
            bonus_reg    <= RST_BONUS;
            stat_reg     <= STAT_OK;
            ran_reg      <= 1'b0;
            total_reg    <= '0;
            win_reg      <= '0;
            pres_reg     <= 1'b0;
            walk_reg     <= '0;
            acc_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            stat_reg     <= stat_next;
            ran_reg      <= ran_next;
            total_reg    <= total_next;
            win_reg      <= win_next;
            pres_reg     <= pres_next;
            walk_reg     <= walk_next;
            acc_reg      <= acc_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MAX:   max_reg   <= cfg_data;
                    CFG_MIN:   min_reg   <= cfg_data;
                    CFG_START: start_reg <= cfg_data;
                    CFG_PEN:   pen_reg   <= cfg_data;
                    CFG_BONUS: bonus_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_OUT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg   <= kind;
            s_reg      <= IDX_W'(slot);
            inside_reg <= (32'(slot) < NUM_SLOTS);
            par_ok_reg <= (32'(parent_slot) < NUM_SLOTS) && use_vec[IDX_W'(parent_slot)];
            sprio_reg  <= start_priority;
            chg_reg    <= ticket_change;
            rnd_reg    <= random_value;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            o_stat_reg <= stat_reg;
            o_ran_reg  <= ran_reg;
            o_wv_reg   <= pres_reg;
            o_ws_reg   <= pres_reg ? 6'(win_reg) : 6'd0;
            o_tk_reg   <= inside_reg ? cur_tk : '0;
            o_pr_reg   <= used ? rd_pr : '0;
            o_tot_reg  <= (total_reg > SUM_W'({OTOT_W{1'b1}})) ? {OTOT_W{1'b1}}
                                                              : OTOT_W'(total_reg);
        end
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = ov_reg;
    assign status        = o_stat_reg;
    assign ran_lottery   = o_ran_reg;
    assign winner_valid  = o_wv_reg;
    assign winner_slot   = o_ws_reg;
    assign slot_tickets  = o_tk_reg;
    assign slot_priority = o_pr_reg;
    assign ticket_total  = o_tot_reg;

    // a held winner is always a slot in use
    a_winner_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        pres_reg |-> use_vec[win_reg])
        else $error("winner slot not in use");

    a_ran_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_ran_reg) |-> (o_stat_reg == STAT_OK))
        else $error("draw reported with error status");

    a_mod_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> (state_reg == ST_MOD))
        else $error("remainder unit busy outside draw");

    a_draw_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mod_start |-> (total_reg != '0))
        else $error("draw started on zero total");

endmodule

[rtl/core/lts_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_mod
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lts_mod
    import lts_pkg::*;
#(
    parameter int SUM_W = 13
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [SUM_W-1:0] rem
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [SUM_W-1:0] dvs_reg, dvs_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[RND_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RND_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = SUM_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[SUM_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/lts_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_table
// Slot table: in-use flags in flops, ticket and priority memories.
// ----------------------------------------------------------------------------
module lts_table
    import lts_pkg::*;
#(
    parameter int NUM_SLOTS = 64,
    parameter int IDX_W     = 6
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lts_wr_ctl_t          wr_ctl,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [TK_W-1:0]      wr_tk,
    input  logic [PR_W-1:0]      wr_pr,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic                 rd_use,
    output logic [TK_W-1:0]      rd_tk,
    output logic [PR_W-1:0]      rd_pr,
    output logic [NUM_SLOTS-1:0] use_vec
);

    logic [NUM_SLOTS-1:0] use_reg;
    logic [TK_W-1:0]      tk_mem [NUM_SLOTS];
    logic [PR_W-1:0]      pr_mem [NUM_SLOTS];
    logic                 rd_use_reg;
    logic [TK_W-1:0]      rd_tk_reg;
    logic [PR_W-1:0]      rd_pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg    <= '0;
            rd_use_reg <= 1'b0;
        end
        else
        begin
            if (wr_ctl.we_use)
            begin
                use_reg[wr_addr] <= wr_ctl.use_val;
            end
            rd_use_reg <= use_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.we_tk)
        begin
            tk_mem[wr_addr] <= wr_tk;
        end
        if (wr_ctl.we_pr)
        begin
            pr_mem[wr_addr] <= wr_pr;
        end
        rd_tk_reg <= tk_mem[rd_addr];
        rd_pr_reg <= pr_mem[rd_addr];
    end

    assign rd_use  = rd_use_reg;
    assign rd_tk   = rd_tk_reg;
    assign rd_pr   = rd_pr_reg;
    assign use_vec = use_reg;

endmodule
